>>> rtl/rtzda_pkg.sv
// Package: types, constants and calendar helpers for the time-zone date adjust unit.
package rtzda_pkg;

	localparam int BASE_YEAR = 2000;

	// Offset from BASE_YEAR that lands on a century year, and whether that year leaps.
	localparam int       CENT_OFF  = (100 - (BASE_YEAR % 100)) % 100;
	localparam logic     CENT_LEAP = ((BASE_YEAR + CENT_OFF) % 400) == 0;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [6:0] bcd_second;
		logic [6:0] bcd_minute;
		logic [5:0] bcd_hour;
		logic [5:0] bcd_day;
		logic [4:0] bcd_month;
		logic [7:0] bcd_year;
	} snapshot_t;

	typedef struct packed {
		logic [5:0]  adj_second;
		logic [5:0]  adj_minute;
		logic [4:0]  adj_hour;
		logic [4:0]  adj_day;
		logic [3:0]  adj_month;
		logic [11:0] adj_year;
	} result_t;

	// Decoded and clamped clock fields handed from decode to carry logic.
	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year_off;
		logic       leap;
	} decoded_t;

	// High nibble times ten plus low nibble, no digit check.
	function automatic logic [7:0] bcd_dec(input logic [7:0] v);
		return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
	endfunction

	// Gregorian leap test for BASE_YEAR + year_off, year_off in 0..99.
	function automatic logic is_leap(input logic [6:0] year_off);
		logic [11:0] full;
		full = 12'(BASE_YEAR) + {5'b00000, year_off};
		return (full[1:0] == 2'b00) && ((year_off != 7'(CENT_OFF)) || CENT_LEAP);
	endfunction

	// Days in month (1..12).
	function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
		logic [3:0] idx;
		idx = month - 4'd1;
		if (month == MONTH_FEB && leap)
			return 5'd29;
		return MONTH_LEN[idx];
	endfunction

endpackage

>>> rtl/rtc_time_zone_date_adjust_unit.sv
// Top level: time-zone adjustment of BCD real-time-clock snapshots.
//
// Usage:
//   Present a BCD clock snapshot on snapshot and pulse start. An item is
//   taken at every rising edge where start is high and busy is low; busy
//   stays low, so an item may be issued in every cycle.
//   After an item is taken and has passed the input and result registers,
//   done is high for exactly one cycle and result holds the decoded
//   second and minute and the hour, day, month and full year after the
//   signed hour offset is applied. Items come out in issue order.
//   Each item passes an input register, then decode, clamp and the
//   day carry or borrow in one pass of logic, then the result register.
//   Throughput is one item per cycle.
//   The receiver cannot stall: done is a strobe and result must be taken
//   in the cycle it is shown.
//   cfg_we writes the 5-bit two's-complement hour offset from cfg_wdata;
//   write it only while no item is in flight.
//   Reset clears the offset to zero and drops any item in flight.
module rtc_time_zone_date_adjust_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rtzda_pkg::snapshot_t snapshot,
	output logic                 done,
	output rtzda_pkg::result_t   result,
	input  logic                 cfg_we,
	input  logic [4:0]           cfg_wdata
);

	logic                 valid_s1, valid_s2;
	rtzda_pkg::snapshot_t snap_s1;
	rtzda_pkg::decoded_t  dec;
	rtzda_pkg::result_t   res_comb, result_s2;
	logic [4:0]           tz_q;

	// The pipeline never backs up, so accept every cycle.
	assign busy = 1'b0;

	// Hold the time-zone offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tz_q <= 5'd0;
		else if (cfg_we)
			tz_q <= cfg_wdata;
	end

	// Advance the valid strobes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	// Capture the payload; no reset needed.
	always_ff @(posedge clk) begin
		if (start && !busy)
			snap_s1 <= snapshot;
		if (valid_s1)
			result_s2 <= res_comb;
	end

	rtzda_decode u_decode (
		.snap (snap_s1),
		.dec  (dec)
	);

	rtzda_carry u_carry (
		.dec       (dec),
		.tz_offset (tz_q),
		.res       (res_comb)
	);

	assign done   = valid_s2;
	assign result = result_s2;

	// Every taken item shows up on done after the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("item did not complete after two cycles");

	// No result without an item that passed through the input register.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without an item");

	// Adjusted time stays on the calendar.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.adj_hour < 5'd24) && (result.adj_day != 5'd0) &&
			(result.adj_month >= 4'd1) && (result.adj_month <= 4'd12))
		else $error("adjusted time out of range");

	// Year moves at most one step outside the base century.
	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.adj_year >= 12'(rtzda_pkg::BASE_YEAR - 1)) &&
			(result.adj_year <= 12'(rtzda_pkg::BASE_YEAR + 100)))
		else $error("adjusted year out of range");

endmodule

>>> rtl/rtzda_decode.sv
// Decode: BCD to binary for each clock field, with range clamping.
module rtzda_decode (
	input  rtzda_pkg::snapshot_t snap,
	output rtzda_pkg::decoded_t  dec
);

	logic [7:0] sec_raw, min_raw, hour_raw, day_raw, mon_raw, year_raw;
	logic [3:0] month;
	logic [6:0] year_off;
	logic       leap;
	logic [4:0] dim;

	always_comb begin
		sec_raw  = rtzda_pkg::bcd_dec({1'b0, snap.bcd_second});
		min_raw  = rtzda_pkg::bcd_dec({1'b0, snap.bcd_minute});
		hour_raw = rtzda_pkg::bcd_dec({2'b00, snap.bcd_hour});
		day_raw  = rtzda_pkg::bcd_dec({2'b00, snap.bcd_day});
		mon_raw  = rtzda_pkg::bcd_dec({3'b000, snap.bcd_month});
		year_raw = rtzda_pkg::bcd_dec(snap.bcd_year);

		if (mon_raw == 8'd0)
			month = rtzda_pkg::MONTH_JAN;
		else if (mon_raw > 8'd12)
			month = rtzda_pkg::MONTH_DEC;
		else
			month = mon_raw[3:0];

		year_off = (year_raw > 8'd99) ? 7'd99 : year_raw[6:0];
		leap     = rtzda_pkg::is_leap(year_off);
		dim      = rtzda_pkg::days_in(month, leap);

		dec.second   = (sec_raw > 8'd59) ? 6'd59 : sec_raw[5:0];
		dec.minute   = (min_raw > 8'd59) ? 6'd59 : min_raw[5:0];
		dec.hour     = (hour_raw > 8'd23) ? 5'd23 : hour_raw[4:0];
		dec.month    = month;
		dec.year_off = year_off;
		dec.leap     = leap;
		if (day_raw == 8'd0)
			dec.day = 5'd1;
		else if (day_raw > {3'b000, dim})
			dec.day = dim;
		else
			dec.day = day_raw[4:0];
	end

endmodule

>>> rtl/rtzda_carry.sv
// Carry: apply the hour offset and ripple a day carry or borrow into month and year.
module rtzda_carry (
	input  rtzda_pkg::decoded_t dec,
	input  logic [4:0]          tz_offset,
	output rtzda_pkg::result_t  res
);

	logic [6:0]  hour_sum;
	logic        borrow, carry;
	logic [4:0]  dim;
	logic [11:0] year_full;

	always_comb begin
		hour_sum  = {2'b00, dec.hour} + {{2{tz_offset[4]}}, tz_offset};
		borrow    = hour_sum[6];
		carry     = !hour_sum[6] && (hour_sum >= 7'd24);
		dim       = rtzda_pkg::days_in(dec.month, dec.leap);
		year_full = 12'(rtzda_pkg::BASE_YEAR) + {5'b00000, dec.year_off};

		res.adj_second = dec.second;
		res.adj_minute = dec.minute;
		res.adj_hour   = hour_sum[4:0];
		res.adj_day    = dec.day;
		res.adj_month  = dec.month;
		res.adj_year   = year_full;

		if (borrow) begin
			res.adj_hour = 5'(hour_sum + 7'd24);
			if (dec.day == 5'd1) begin
				// Step back into the last day of the previous month.
				if (dec.month == rtzda_pkg::MONTH_JAN) begin
					res.adj_month = rtzda_pkg::MONTH_DEC;
					res.adj_year  = year_full - 12'd1;
				end else begin
					res.adj_month = dec.month - 4'd1;
				end
				res.adj_day = rtzda_pkg::days_in(res.adj_month, dec.leap);
			end else begin
				res.adj_day = dec.day - 5'd1;
			end
		end else if (carry) begin
			res.adj_hour = 5'(hour_sum - 7'd24);
			if (dec.day == dim) begin
				res.adj_day = 5'd1;
				if (dec.month == rtzda_pkg::MONTH_DEC) begin
					res.adj_month = rtzda_pkg::MONTH_JAN;
					res.adj_year  = year_full + 12'd1;
				end else begin
					res.adj_month = dec.month + 4'd1;
				end
			end else begin
				res.adj_day = dec.day + 5'd1;
			end
		end
	end

endmodule

>>> bench/tb.sv
// Self-checking testbench for the time-zone date adjust unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 6;   // two-stage pipe plus margin
	localparam int CHUNK_ITEMS = 170;
	localparam int CHUNKS      = 6;
	localparam int SHOW_MAX    = 10;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	rtzda_pkg::snapshot_t snapshot;
	logic                 done;
	rtzda_pkg::result_t   result;
	logic                 cfg_we;
	logic [4:0]           cfg_wdata;

	// Items waiting to be offered, and predicted local times waiting for done.
	rtzda_pkg::snapshot_t snapshot_q[$];
	rtzda_pkg::result_t   local_time_q[$];

	int zone_offset;      // bench copy of the hour offset register
	int send_idle_pct;    // chance in a hundred that the driver holds start low
	int items_taken;
	int results_seen;
	int mismatch_count;
	int settings_used;
	int cycle_count;

	rtc_time_zone_date_adjust_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.snapshot  (snapshot),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// High nibble times ten plus low nibble; bad digits go through as they are.
	function automatic int bcd_value(input logic [7:0] v);
		return int'(v[7:4]) * 10 + int'(v[3:0]);
	endfunction

	function automatic logic [7:0] to_bcd(input int v);
		logic [3:0] tens;
		logic [3:0] ones;
		tens = 4'(v / 10);
		ones = 4'(v % 10);
		return {tens, ones};
	endfunction

	function automatic int month_days(input int mon, input int yr);
		bit leap;
		leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		case (mon)
			2:             return leap ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// Decode, clamp, shift the hour and ripple at most one day of carry or borrow.
	function automatic rtzda_pkg::result_t predict_local_time(input rtzda_pkg::snapshot_t s,
			input int offset);
		int sec;
		int min;
		int hr;
		int dy;
		int mo;
		int yr;
		rtzda_pkg::result_t r;
		sec = bcd_value({1'b0, s.bcd_second});
		min = bcd_value({1'b0, s.bcd_minute});
		hr  = bcd_value({2'b00, s.bcd_hour});
		dy  = bcd_value({2'b00, s.bcd_day});
		mo  = bcd_value({3'b000, s.bcd_month});
		yr  = bcd_value(s.bcd_year);
		if (sec > 59) sec = 59;
		if (min > 59) min = 59;
		if (hr > 23) hr = 23;
		if (yr > 99) yr = 99;
		yr = rtzda_pkg::BASE_YEAR + yr;
		if (mo < 1) mo = 1;
		if (mo > 12) mo = 12;
		if (dy < 1) dy = 1;
		if (dy > month_days(mo, yr)) dy = month_days(mo, yr);

		hr = hr + offset;
		if (hr < 0) begin
			// Step back into the last day of the previous month, or year.
			hr = hr + 24;
			dy = dy - 1;
			if (dy < 1) begin
				mo = mo - 1;
				if (mo < 1) begin
					mo = 12;
					yr = yr - 1;
				end
				dy = month_days(mo, yr);
			end
		end else if (hr >= 24) begin
			// Roll forward onto the first of the next month, or year.
			hr = hr - 24;
			dy = dy + 1;
			if (dy > month_days(mo, yr)) begin
				dy = 1;
				mo = mo + 1;
				if (mo > 12) begin
					mo = 1;
					yr = yr + 1;
				end
			end
		end

		r.adj_second = 6'(sec);
		r.adj_minute = 6'(min);
		r.adj_hour   = 5'(hr);
		r.adj_day    = 5'(dy);
		r.adj_month  = 4'(mo);
		r.adj_year   = 12'(yr);
		return r;
	endfunction

	function automatic rtzda_pkg::snapshot_t clock_snapshot(input int yr, input int mo,
			input int dy, input int hr, input int min, input int sec);
		rtzda_pkg::snapshot_t s;
		s.bcd_second = 7'(to_bcd(sec));
		s.bcd_minute = 7'(to_bcd(min));
		s.bcd_hour   = 6'(to_bcd(hr));
		s.bcd_day    = 6'(to_bcd(dy));
		s.bcd_month  = 5'(to_bcd(mo));
		s.bcd_year   = to_bcd(yr);
		return s;
	endfunction

	// Mostly legal clock readings pushed toward day, month and year edges;
	// the rest is raw noise so that every register bit toggles.
	function automatic rtzda_pkg::snapshot_t random_snapshot();
		rtzda_pkg::snapshot_t s;
		int yr;
		int mo;
		int dy;
		int hr;
		int last;
		if ($urandom_range(99) < 25) begin
			s.bcd_second = 7'($urandom);
			s.bcd_minute = 7'($urandom);
			s.bcd_hour   = 6'($urandom);
			s.bcd_day    = 6'($urandom);
			s.bcd_month  = 5'($urandom);
			s.bcd_year   = 8'($urandom);
			return s;
		end
		case ($urandom_range(3))
			0:       yr = 0;
			1:       yr = 99;
			default: yr = $urandom_range(99);
		endcase
		case ($urandom_range(4))
			0:       mo = 1;
			1:       mo = 2;
			2:       mo = 3;
			3:       mo = 12;
			default: mo = $urandom_range(1, 12);
		endcase
		last = month_days(mo, rtzda_pkg::BASE_YEAR + yr);
		case ($urandom_range(3))
			0:       dy = 1;
			1:       dy = last;
			2:       dy = $urandom_range(last - 1, 31);
			default: dy = $urandom_range(1, 31);
		endcase
		case ($urandom_range(2))
			0:       hr = $urandom_range(0, 3);
			1:       hr = $urandom_range(20, 23);
			default: hr = $urandom_range(0, 23);
		endcase
		return clock_snapshot(yr, mo, dy, hr, $urandom_range(59), $urandom_range(59));
	endfunction

	// Driver: record the item taken at this edge, then offer the next one or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				local_time_q.push_back(predict_local_time(snapshot, zone_offset));
				items_taken++;
			end
			if (start && busy) begin
				// hold the current item until it is taken
			end else if (snapshot_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				start    <= 1'b1;
				snapshot <= snapshot_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: done is a one-cycle strobe, so check every result as it passes.
	always @(posedge clk) begin
		rtzda_pkg::result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (local_time_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_MAX)
					$display("%0t: result with no item outstanding: %0d-%0d-%0d %0d:%0d:%0d",
						$realtime, result.adj_year, result.adj_month, result.adj_day,
						result.adj_hour, result.adj_minute, result.adj_second);
			end else begin
				want = local_time_q.pop_front();
				if (result.adj_second !== want.adj_second
						|| result.adj_minute !== want.adj_minute
						|| result.adj_hour !== want.adj_hour
						|| result.adj_day !== want.adj_day
						|| result.adj_month !== want.adj_month
						|| result.adj_year !== want.adj_year) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_MAX)
						$display("%0t: y/m/d h:m:s expected %0d/%0d/%0d %0d:%0d:%0d got %0d/%0d/%0d %0d:%0d:%0d",
							$realtime,
							want.adj_year, want.adj_month, want.adj_day,
							want.adj_hour, want.adj_minute, want.adj_second,
							result.adj_year, result.adj_month, result.adj_day,
							result.adj_hour, result.adj_minute, result.adj_second);
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, local_time_q.size());
			$display("rtc_time_zone_date_adjust_unit regression: fail");
			$finish;
		end
	end

	// Wait until every item is taken and every result has come back, then
	// let the pipe settle before anything else changes.
	task automatic drain();
		while (snapshot_q.size() != 0 || start || local_time_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the offset register; only called with the pipe empty.
	task automatic set_zone_offset(input int off);
		@(posedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= 5'(off);
		zone_offset = off;
		settings_used++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int off;
		rtzda_pkg::snapshot_t s;
		arst_n        = 1'b0;
		start         = 1'b0;
		snapshot      = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		zone_offset   = 0;
		send_idle_pct = 12;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset offset of zero: decode and clamp corners pass straight through.
		snapshot_q.push_back('0);
		snapshot_q.push_back('1);
		snapshot_q.push_back(clock_snapshot(24, 6, 15, 12, 34, 56));
		snapshot_q.push_back(clock_snapshot(1, 2, 29, 10, 0, 0));   // no Feb 29 in 2001
		snapshot_q.push_back(clock_snapshot(7, 4, 31, 10, 0, 0));   // April has 30 days
		s = clock_snapshot(9, 9, 9, 9, 9, 9);
		s.bcd_second = 7'h5A;                                       // bad digits
		s.bcd_hour   = 6'h1F;
		s.bcd_day    = 6'h3A;
		s.bcd_month  = 5'h0F;
		snapshot_q.push_back(s);
		drain();

		// Most negative offset: borrow across day, month, year and Feb 29.
		set_zone_offset(-16);
		snapshot_q.push_back(clock_snapshot(0, 1, 1, 0, 0, 0));    // back into 1999
		snapshot_q.push_back(clock_snapshot(4, 3, 1, 3, 30, 0));   // leap year
		snapshot_q.push_back(clock_snapshot(0, 3, 1, 0, 0, 0));    // century leap
		snapshot_q.push_back(clock_snapshot(1, 3, 1, 5, 0, 0));
		snapshot_q.push_back(clock_snapshot(10, 5, 1, 15, 59, 59));
		snapshot_q.push_back(clock_snapshot(10, 5, 1, 16, 0, 0));  // lands on hour 0
		drain();

		// Most positive offset: carry across day, month, year and Feb 29.
		set_zone_offset(15);
		snapshot_q.push_back(clock_snapshot(99, 12, 31, 23, 59, 59)); // into 2100
		snapshot_q.push_back(clock_snapshot(4, 2, 28, 9, 0, 0));
		snapshot_q.push_back(clock_snapshot(4, 2, 29, 9, 0, 0));
		snapshot_q.push_back(clock_snapshot(1, 2, 28, 9, 0, 0));
		snapshot_q.push_back(clock_snapshot(50, 1, 31, 8, 0, 0));    // lands on hour 23
		snapshot_q.push_back(clock_snapshot(50, 1, 31, 9, 0, 0));
		snapshot_q.push_back(clock_snapshot(50, 6, 30, 20, 0, 0));
		drain();

		// Random chunks: light sender gaps, then heavy gaps, then none, with
		// the nominal zone limits, the register extremes and random offsets.
		for (int c = 0; c < CHUNKS; c++) begin
			case (c)
				0:       off = -12;
				1:       off = 14;
				2:       off = -16;
				3:       off = 15;
				default: off = int'($signed(5'($urandom)));
			endcase
			send_idle_pct = (c < 2) ? 12 : (c < 4) ? 83 : 0;
			set_zone_offset(off);
			for (int i = 0; i < CHUNK_ITEMS; i++)
				snapshot_q.push_back(random_snapshot());
			drain();
		end

		$display("checked %0d snapshots across %0d offset settings, %0d results, %0d mismatches",
			items_taken, settings_used, results_seen, mismatch_count);
		if (mismatch_count == 0 && local_time_q.size() == 0)
			$display("rtc_time_zone_date_adjust_unit regression: pass");
		else
			$display("rtc_time_zone_date_adjust_unit regression: fail");
		$finish;
	end

endmodule
